// ----- src/lru_kv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared types and constants for the cache top level and its testbench.
// ----------------------------------------------------------------------------
package lru_kv_pkg;

	localparam int unsigned MaxEntriesDefault = 64;
	localparam int unsigned CapWidth = 7;
	localparam int unsigned CapResetDefault = 64;

	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_PUT = 1'b1
	} cmd_t;

	typedef struct packed {
		logic        command;
		logic [31:0] key;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] read_value;
		logic        evicted;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_AGE,
		ST_WRITE,
		ST_RESP
	} state_t;

endpackage
`default_nettype wire

// ----- src/lru_key_value_cache_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key-value cache top level
// Key-value store with least-recently-used replacement in on-chip RAM.
// ----------------------------------------------------------------------------
// Usage: an item (command, key, value) enters on in_valid/in_ready. Each item
// gives one result (hit, read_value, evicted) on out_valid/out_ready.
// Entries sit packed in slots 0..count-1 of three RAMs (key, value, rank).
// An item is handled one at a time: a scan reads one slot a cycle to find
// the key (and on a full put the oldest slot); for a hit or a put a second
// pass over the occupied slots then ages the ranks and the entry is written,
// while a get miss goes straight to the result. The block is ready again in
// the cycle after the result is taken. While the receiver stalls the block
// holds the result and takes no new item.
// Reset empties the store (count zero) and sets capacity to 64; no clearing
// pass is needed. A write of the capacity register empties the store again.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
	parameter int unsigned MAX_ENTRIES = lru_kv_pkg::MaxEntriesDefault
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [6:0]              cfg_wdata,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire lru_kv_pkg::req_t        in_data,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output lru_kv_pkg::rsp_t             out_data
);

	localparam int unsigned AW = $clog2(MAX_ENTRIES);
	localparam int unsigned CW = AW + 1;
	localparam int unsigned CapW = lru_kv_pkg::CapWidth;

	lru_kv_pkg::state_t state_q, state_d;

	logic [CapW-1:0] cap_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   ptr_q;      // slot whose read is issued
	logic [CW-1:0]   rd_idx_s1;  // slot whose data returns now
	logic            rd_vld_s1;
	lru_kv_pkg::req_t req_q;
	logic            hit_q;
	logic [AW-1:0]   found_q;
	logic [AW-1:0]   found_rank_q;
	logic            old_q;
	logic [AW-1:0]   old_slot_q;
	logic [31:0]     rval_q;
	logic            evict_q;
	logic [AW-1:0]   limit_q;
	logic [AW-1:0]   slot_q;
	logic [CW-1:0]   eff_cap;

	logic            k_we, v_we, r_we;
	logic [AW-1:0]   k_wa, v_wa, r_wa, raddr;
	logic [31:0]     k_wd, v_wd, k_rd, v_rd;
	logic [AW-1:0]   r_wd, r_rd;

	lru_kv_ram #(.Width(32), .Depth(MAX_ENTRIES)) u_key (
		.clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(raddr), .rdata(k_rd));
	lru_kv_ram #(.Width(32), .Depth(MAX_ENTRIES)) u_val (
		.clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(raddr), .rdata(v_rd));
	lru_kv_ram #(.Width(AW), .Depth(MAX_ENTRIES)) u_rank (
		.clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(raddr), .rdata(r_rd));

	// Effective capacity: zero acts as one, values above the depth saturate.
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (32'(cap_q) > MAX_ENTRIES) begin
			eff_cap = CW'(MAX_ENTRIES);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	assign raddr = ptr_q[AW-1:0];
	assign in_ready = (state_q == lru_kv_pkg::ST_IDLE);
	assign out_valid = (state_q == lru_kv_pkg::ST_RESP);
	assign out_data.hit = hit_q;
	assign out_data.read_value = rval_q;
	assign out_data.evicted = evict_q;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lru_kv_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = lru_kv_pkg::ST_SCAN;
				end
			end
			lru_kv_pkg::ST_SCAN: begin
				if (ptr_q >= count_q && !rd_vld_s1) begin
					state_d = lru_kv_pkg::ST_DECIDE;
				end
			end
			lru_kv_pkg::ST_DECIDE: begin
				if (hit_q || req_q.command == lru_kv_pkg::CMD_PUT) begin
					state_d = lru_kv_pkg::ST_AGE;
				end else begin
					state_d = lru_kv_pkg::ST_RESP;
				end
			end
			lru_kv_pkg::ST_AGE: begin
				if (ptr_q >= count_q && !rd_vld_s1) begin
					state_d = lru_kv_pkg::ST_WRITE;
				end
			end
			lru_kv_pkg::ST_WRITE: state_d = lru_kv_pkg::ST_RESP;
			lru_kv_pkg::ST_RESP: begin
				if (out_ready) begin
					state_d = lru_kv_pkg::ST_IDLE;
				end
			end
			default: state_d = lru_kv_pkg::ST_IDLE;
		endcase
	end

	// RAM write controls: aging pass, then the final entry write.
	always_comb begin
		k_we = 1'b0;
		v_we = 1'b0;
		r_we = 1'b0;
		k_wa = slot_q;
		v_wa = slot_q;
		r_wa = rd_idx_s1[AW-1:0];
		k_wd = req_q.key;
		v_wd = req_q.value;
		r_wd = r_rd + AW'(1);
		unique case (state_q)
			lru_kv_pkg::ST_AGE: begin
				r_we = rd_vld_s1 && (r_rd < limit_q);
			end
			lru_kv_pkg::ST_WRITE: begin
				r_we = 1'b1;
				r_wa = slot_q;
				r_wd = '0;
				k_we = !hit_q;
				v_we = !hit_q || req_q.command == lru_kv_pkg::CMD_PUT;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lru_kv_pkg::ST_IDLE;
			cap_q     <= CapW'(lru_kv_pkg::CapResetDefault);
			count_q   <= '0;
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cap_q   <= cfg_wdata;
				count_q <= '0;
			end
			unique case (state_q)
				lru_kv_pkg::ST_IDLE: begin
					ptr_q     <= '0;
					rd_vld_s1 <= 1'b0;
				end
				lru_kv_pkg::ST_SCAN, lru_kv_pkg::ST_AGE: begin
					if (ptr_q < count_q) begin
						ptr_q     <= ptr_q + CW'(1);
						rd_vld_s1 <= 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
					end
				end
				lru_kv_pkg::ST_DECIDE: begin
					ptr_q     <= '0;
					rd_vld_s1 <= 1'b0;
					if (!hit_q && req_q.command == lru_kv_pkg::CMD_PUT
					    && count_q < eff_cap) begin
						count_q <= count_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers for the item in flight.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= ptr_q;
		unique case (state_q)
			lru_kv_pkg::ST_IDLE: begin
				req_q   <= in_data;
				hit_q   <= 1'b0;
				old_q   <= 1'b0;
				rval_q  <= '0;
				evict_q <= 1'b0;
			end
			lru_kv_pkg::ST_SCAN: begin
				if (rd_vld_s1) begin
					if (!hit_q && k_rd == req_q.key) begin
						hit_q        <= 1'b1;
						found_q      <= rd_idx_s1[AW-1:0];
						found_rank_q <= r_rd;
						if (req_q.command == lru_kv_pkg::CMD_GET) begin
							rval_q <= v_rd;
						end
					end
					if (!old_q && CW'(r_rd) == count_q - CW'(1)) begin
						old_q      <= 1'b1;
						old_slot_q <= rd_idx_s1[AW-1:0];
					end
				end
			end
			lru_kv_pkg::ST_DECIDE: begin
				if (hit_q) begin
					slot_q  <= found_q;
					limit_q <= found_rank_q;
				end else if (req_q.command == lru_kv_pkg::CMD_PUT
				             && count_q >= eff_cap) begin
					slot_q  <= old_q ? old_slot_q : '0;
					limit_q <= AW'(count_q - CW'(1));
					evict_q <= 1'b1;
				end else begin
					slot_q  <= count_q[AW-1:0];
					limit_q <= count_q[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- src/lru_kv_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module lru_kv_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get and put items with random idling on both channels, predicts
// every result with a behavioral LRU store and checks each field in order.
// ----------------------------------------------------------------------------

// Behavioral LRU store and queue of expected results.
class lru_scoreboard;
	localparam int Slots = 64;

	logic [31:0] key_mem[Slots];
	logic [31:0] val_mem[Slots];
	int unsigned age_mem[Slots];
	int unsigned fill;
	int unsigned cap;
	lru_kv_pkg::rsp_t pending[$];
	int unsigned errors;

	function new();
		fill = 0;
		cap = 64;
		errors = 0;
	endfunction

	// A capacity write forgets every entry.
	function void set_capacity(logic [6:0] c);
		cap = c;
		fill = 0;
	endfunction

	function int unsigned limit_cap();
		if (cap < 1) begin
			return 1;
		end
		if (cap > Slots) begin
			return Slots;
		end
		return cap;
	endfunction

	function void age_younger(int unsigned lim);
		for (int s = 0; s < fill; s++) begin
			if (age_mem[s] < lim) begin
				age_mem[s]++;
			end
		end
	endfunction

	// Update the store for one accepted item and queue its result.
	function void note_request(lru_kv_pkg::req_t rq);
		lru_kv_pkg::rsp_t rs;
		int found;
		int slot;
		found = -1;
		rs = '0;
		for (int s = 0; s < fill; s++) begin
			if (found < 0 && key_mem[s] == rq.key) begin
				found = s;
			end
		end
		if (found >= 0) begin
			rs.hit = 1'b1;
			age_younger(age_mem[found]);
			age_mem[found] = 0;
			if (rq.command == lru_kv_pkg::CMD_GET) begin
				rs.read_value = val_mem[found];
			end else begin
				val_mem[found] = rq.value;
			end
		end else if (rq.command == lru_kv_pkg::CMD_PUT) begin
			if (fill >= limit_cap()) begin
				slot = 0;
				for (int s = fill - 1; s >= 0; s--) begin
					if (age_mem[s] == fill - 1) begin
						slot = s;
					end
				end
				age_younger(fill - 1);
				rs.evicted = 1'b1;
			end else begin
				slot = fill;
				age_younger(fill);
				fill++;
			end
			key_mem[slot] = rq.key;
			val_mem[slot] = rq.value;
			age_mem[slot] = 0;
		end
		pending.push_back(rs);
	endfunction

	// Compare one result with the oldest expectation.
	function void check_result(lru_kv_pkg::rsp_t got);
		lru_kv_pkg::rsp_t exp_rs;
		if (pending.size() == 0) begin
			$error("unexpected result %p", got);
			errors++;
			return;
		end
		exp_rs = pending.pop_front();
		if (got.hit !== exp_rs.hit) begin
			$error("hit: expected %0d, actual %0d", exp_rs.hit, got.hit);
			errors++;
		end
		if (got.read_value !== exp_rs.read_value) begin
			$error("read_value: expected %h, actual %h", exp_rs.read_value, got.read_value);
			errors++;
		end
		if (got.evicted !== exp_rs.evicted) begin
			$error("evicted: expected %0d, actual %0d", exp_rs.evicted, got.evicted);
			errors++;
		end
	endfunction
endclass

module testbench;

	localparam int unsigned CycleLimit = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [6:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	lru_kv_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	lru_kv_pkg::rsp_t out_data;

	lru_scoreboard board = new();
	logic [31:0] key_pool[16];
	int unsigned cycle_count = 0;
	int unsigned hold_off = 0;
	bit hold_request = 1'b0;

	lru_key_value_cache_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned gap_len();
		if ($urandom_range(0, 19) == 0) begin
			return $urandom_range(10, 60);
		end
		if ($urandom_range(0, 2) == 0) begin
			return 0;
		end
		return $urandom_range(0, 3);
	endfunction

	// Offer one item and wait for it to be accepted.
	task automatic send_item(input logic cmd, input logic [31:0] k, input logic [31:0] v);
		lru_kv_pkg::req_t rq;
		rq.command = cmd;
		rq.key = k;
		rq.value = v;
		in_valid <= 1'b1;
		in_data <= rq;
		do begin
			@(posedge clk);
		end while (!in_ready);
		board.note_request(rq);
	endtask

	task automatic send_random(input bit random_gaps);
		logic [31:0] k;
		int unsigned g;
		if ($urandom_range(0, 9) < 8) begin
			k = key_pool[$urandom_range(0, 15)];
		end else begin
			k = $urandom();
		end
		send_item(1'($urandom_range(0, 1)), k, $urandom());
		if (random_gaps) begin
			g = gap_len();
			if (g > 0) begin
				in_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (300) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [6:0] c);
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_capacity(c);
	endtask

	// Receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			board.check_result(out_data);
		end
		if (hold_request) begin
			hold_off <= 400;
			hold_request <= 1'b0;
			out_ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= (hold_off == 1);
		end else begin
			out_ready <= ($urandom_range(0, 9) < 7);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Main stimulus sequence.
	initial begin
		logic [6:0] caps[6];
		caps = '{7'd1, 7'd2, 7'd64, 7'd127, 7'd0, 7'd5};
		for (int i = 0; i < 16; i++) begin
			key_pool[i] = $urandom();
		end
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0;
		key_pool[3] = 32'hFFFF_FFFF;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme keys and values, miss, hit, update, eviction.
		send_item(lru_kv_pkg::CMD_GET, 32'h8000_0000, 32'h0);
		send_item(lru_kv_pkg::CMD_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
		send_item(lru_kv_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h0);
		send_item(lru_kv_pkg::CMD_GET, 32'h8000_0000, 32'h1234_5678);
		send_item(lru_kv_pkg::CMD_PUT, 32'h8000_0000, 32'hA5A5_5A5A);
		send_item(lru_kv_pkg::CMD_GET, 32'h8000_0000, 32'h0);
		send_item(lru_kv_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0);
		send_item(lru_kv_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
		send_item(lru_kv_pkg::CMD_GET, 32'h0000_0000, 32'h0);
		drain();
		write_capacity(7'd2);
		send_item(lru_kv_pkg::CMD_PUT, 32'd1, 32'd11);
		send_item(lru_kv_pkg::CMD_PUT, 32'd2, 32'd22);
		send_item(lru_kv_pkg::CMD_GET, 32'd1, 32'd0);
		send_item(lru_kv_pkg::CMD_PUT, 32'd3, 32'd33);
		send_item(lru_kv_pkg::CMD_GET, 32'd2, 32'd0);
		send_item(lru_kv_pkg::CMD_GET, 32'd1, 32'd0);
		send_item(lru_kv_pkg::CMD_PUT, 32'd1, 32'd44);
		drain();

		// Random phases over several capacities.
		for (int ph = 0; ph < 6; ph++) begin
			write_capacity(caps[ph]);
			for (int i = 0; i < 180; i++) begin
				send_random(1'b1);
			end
			if (ph == 2) begin
				hold_request <= 1'b1;
				for (int i = 0; i < 30; i++) begin
					send_random(1'b0);
				end
			end
			drain();
		end
		write_capacity(7'd64);
		for (int i = 0; i < 220; i++) begin
			send_random(i >= 100);
		end
		drain();

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
